/* sv/cpce_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpce_pkg
// Shared types and codes of the circular playlist cursor engine.
// ----------------------------------------------------------------------------
package cpce_pkg;

  // default list capacity
  localparam int unsigned Capacity = 64;

  // fixed field widths
  localparam int unsigned SongW = 16;
  localparam int unsigned PosW  = 6;
  localparam int unsigned LenW  = 7;
  localparam int unsigned OpW   = 3;
  localparam int unsigned DelW  = 7;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_APPEND = 3'd0,
    OP_DELETE = 3'd1,
    OP_NEXT   = 3'd2,
    OP_PREV   = 3'd3,
    OP_DUMP   = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_SHIFT  = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  // input transaction
  typedef struct packed {
    logic [OpW-1:0]   operation;
    logic [SongW-1:0] song_id;
    logic [DelW-1:0]  delete_position;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [SongW-1:0] current_song;
    logic [PosW-1:0]  current_position;
    logic [LenW-1:0]  list_length;
    logic [1:0]       status;
    logic             wrapped;
    logic             last_result;
  } out_t;

endpackage
`default_nettype wire

/* sv/circular_playlist_cursor_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// circular_playlist_cursor_engine
// Circular playlist with a play cursor, stored in a row of cells.
//
//   channel | signals                            | direction
//   --------+------------------------------------+----------
//   input   | in_valid_i, in_stall_o, in_data_i  | in
//   result  | out_valid_o, out_stall_i, out_data_o| out
//
// One transaction at a time. Acceptance applies append or delete compaction,
// then a read pass rotates the occupied cells once around to pick up the
// cursor song and restore order, then the result is loaded; an empty list
// skips the pass. A dump emits one result per pass cycle, so a stalled
// result channel holds the pass. Reset clears the count, cursor and control;
// cell contents need no clearing.
// ----------------------------------------------------------------------------
module circular_playlist_cursor_engine #(
  parameter int unsigned CAPACITY = cpce_pkg::Capacity
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  cpce_pkg::in_t      in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output cpce_pkg::out_t     out_data_o
);
  import cpce_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned PW = (CW > DelW) ? CW : DelW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PASS = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e        state_q;
  logic [CW-1:0] count_q;
  logic [IW-1:0] cursor_q;
  logic [IW-1:0] step_q;
  logic          dump_q;
  status_e       status_q;
  logic          wrap_q;
  logic [SongW-1:0] song_q;
  logic          out_valid_q;
  out_t          out_q;

  logic [SongW-1:0] head;
  cell_op_e      dec_cmd;
  cell_op_e      cell_cmd;
  logic [IW-1:0] dec_idx;
  logic [CW-1:0] cnt_new;
  logic [IW-1:0] cur_new;
  logic [IW-1:0] cur_fix;
  logic [IW-1:0] cur_adj;
  status_e       dec_st;
  logic          dec_wrap;
  logic          dec_dump;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  logic accept;
  logic out_free;
  logic last_step;
  logic advance;
  logic load_dump;
  logic load_emit;

  // handshake and pass control
  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign last_step = ((CW'(step_q) + CW'(1)) == count_q);
  assign advance   = (state_q == S_PASS) && (!dump_q || out_free);
  assign load_dump = advance && dump_q;
  assign load_emit = (state_q == S_EMIT) && out_free;

  // operation decode against the current list state
  assign pos_ext = PW'(in_data_i.delete_position);
  assign cnt_ext = PW'(count_q);
  assign cur_fix = (CW'(cursor_q) >= count_q) ? '0 : cursor_q;

  always_comb begin
    dec_cmd  = CELL_HOLD;
    dec_idx  = '0;
    cnt_new  = count_q;
    cur_new  = cursor_q;
    cur_adj  = cursor_q;
    dec_st   = ST_OK;
    dec_wrap = 1'b0;
    dec_dump = 1'b0;
    case (in_data_i.operation)
      OP_APPEND: begin
        if (count_q == CapC) begin
          dec_st = ST_FULL;
        end else begin
          dec_cmd = CELL_APPEND;
          cnt_new = count_q + CW'(1);
          if (count_q == '0) cur_new = '0;
        end
      end
      OP_DELETE: begin
        if (count_q == '0) begin
          dec_st = ST_EMPTY;
        end else if ((pos_ext == '0) || (pos_ext > cnt_ext)) begin
          dec_st = ST_INVALID;
        end else begin
          dec_cmd = CELL_SHIFT;
          dec_idx = IW'(pos_ext - PW'(1));
          cnt_new = count_q - CW'(1);
          cur_adj = (dec_idx < cursor_q) ? (cursor_q - IW'(1)) : cursor_q;
          cur_new = (CW'(cur_adj) >= cnt_new) ? '0 : cur_adj;
        end
      end
      OP_NEXT: begin
        if (count_q == '0) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_wrap = ((CW'(cur_fix) + CW'(1)) >= count_q);
          cur_new  = dec_wrap ? '0 : (cur_fix + IW'(1));
        end
      end
      OP_PREV: begin
        if (count_q == '0) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_wrap = (cur_fix == '0);
          cur_new  = dec_wrap ? IW'(count_q - CW'(1)) : (cur_fix - IW'(1));
        end
      end
      OP_DUMP: begin
        if (count_q == '0) begin
          dec_st = ST_EMPTY;
        end else begin
          dec_dump = 1'b1;
        end
      end
      default: dec_st = ST_INVALID;
    endcase
  end

  // cell command: edit on acceptance, rotate during the read pass
  always_comb begin
    cell_cmd = CELL_HOLD;
    if (accept) begin
      cell_cmd = dec_cmd;
    end else if (advance) begin
      cell_cmd = CELL_ROTATE;
    end
  end

  cpce_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cell_cmd),
    .count_i (count_q),
    .idx_i   (dec_idx),
    .song_i  (in_data_i.song_id),
    .head_o  (head)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      step_q      <= '0;
      dump_q      <= 1'b0;
      status_q    <= ST_OK;
      wrap_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            count_q  <= cnt_new;
            cursor_q <= cur_new;
            status_q <= dec_st;
            wrap_q   <= dec_wrap;
            dump_q   <= dec_dump;
            step_q   <= '0;
            state_q  <= (cnt_new != '0) ? S_PASS : S_EMIT;
          end
        end
        S_PASS: begin
          if (advance) begin
            step_q <= step_q + IW'(1);
            if (last_step) state_q <= dump_q ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase

      if (load_dump || load_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // cursor song capture and result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      song_q <= '0;
    end else if (advance && !dump_q && (step_q == cursor_q)) begin
      song_q <= head;
    end

    if (load_dump) begin
      out_q.current_song     <= head;
      out_q.current_position <= PosW'(step_q);
      out_q.list_length      <= LenW'(count_q);
      out_q.status           <= ST_OK;
      out_q.wrapped          <= 1'b0;
      out_q.last_result      <= last_step;
    end else if (load_emit) begin
      out_q.current_song     <= song_q;
      out_q.current_position <= PosW'(cursor_q);
      out_q.list_length      <= LenW'(count_q);
      out_q.status           <= status_q;
      out_q.wrapped          <= wrap_q;
      out_q.last_result      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // list never grows beyond its capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapC)
    else $error("entry count above capacity");

  // cursor stays on a stored entry
  a_cursor_in_list : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (CW'(cursor_q) < count_q))
    else $error("cursor beyond list end");

  // empty list parks the cursor at zero
  a_cursor_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (cursor_q == '0))
    else $error("cursor not zero on empty list");

  // list length only changes when a transaction is taken
  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && (state_q == S_IDLE)) |=> $stable(count_q))
    else $error("entry count changed without a transaction");

  // the final dump result returns the engine to idle
  a_dump_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_dump && last_step) |=> (state_q == S_IDLE) && out_valid_o
      && out_data_o.last_result)
    else $error("dump did not end on its last entry");
`endif

endmodule
`default_nettype wire

/* sv/cpce_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpce_cell
// One list slot: holds a song and takes an append, a compaction step from
// its right neighbor, or a rotation step around the occupied part of the row.
// ----------------------------------------------------------------------------
module cpce_cell #(
  parameter int unsigned CAPACITY = cpce_pkg::Capacity,
  parameter int unsigned INDEX    = 0,
  localparam int unsigned CW      = $clog2(CAPACITY + 1),
  localparam int unsigned IW      = $clog2(CAPACITY)
) (
  input  wire                          clk_i,
  input  cpce_pkg::cell_op_e           cmd_i,
  input  wire [CW-1:0]                 count_i,
  input  wire [IW-1:0]                 idx_i,
  input  wire [cpce_pkg::SongW-1:0]    song_i,
  input  wire [cpce_pkg::SongW-1:0]    next_i,
  input  wire [cpce_pkg::SongW-1:0]    head_i,
  output logic [cpce_pkg::SongW-1:0]   data_o
);
  import cpce_pkg::*;

  localparam logic [CW-1:0] IdxC     = CW'(INDEX);
  localparam logic [CW-1:0] IdxNextC = CW'(INDEX + 1);
  localparam logic [IW-1:0] IdxI     = IW'(INDEX);

  logic [SongW-1:0] data_q;
  logic [SongW-1:0] data_d;

  // per-slot next value
  always_comb begin
    data_d = data_q;
    case (cmd_i)
      CELL_APPEND: begin
        if (IdxC == count_i) data_d = song_i;
      end
      CELL_SHIFT: begin
        if (IdxI >= idx_i) data_d = next_i;
      end
      CELL_ROTATE: begin
        if (IdxNextC < count_i) begin
          data_d = next_i;
        end else if (IdxNextC == count_i) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

/* sv/cpce_chain.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cpce_chain
// Row of list cells; each cell sees its right neighbor and the head cell.
// The head cell is the single read point of the list.
// ----------------------------------------------------------------------------
module cpce_chain #(
  parameter int unsigned CAPACITY = cpce_pkg::Capacity,
  localparam int unsigned CW      = $clog2(CAPACITY + 1),
  localparam int unsigned IW      = $clog2(CAPACITY)
) (
  input  wire                          clk_i,
  input  cpce_pkg::cell_op_e           cmd_i,
  input  wire [CW-1:0]                 count_i,
  input  wire [IW-1:0]                 idx_i,
  input  wire [cpce_pkg::SongW-1:0]    song_i,
  output logic [cpce_pkg::SongW-1:0]   head_o
);
  import cpce_pkg::*;

  logic [SongW-1:0] data [CAPACITY];

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [SongW-1:0] next;
    if (i == CAPACITY - 1) begin : g_tail
      assign next = data[i];
    end else begin : g_mid
      assign next = data[i+1];
    end

    cpce_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd_i),
      .count_i (count_i),
      .idx_i   (idx_i),
      .song_i  (song_i),
      .next_i  (next),
      .head_i  (data[0]),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the circular playlist cursor engine. A directed
// opening covers empty-list commands, single-entry wrap, invalid and edge
// delete positions and unknown opcodes. Random traffic then fills the list
// to capacity, overfills it, and mixes deletes, cursor moves and dumps.
// Every accepted command is run through a behavioral playlist model, and
// each result is matched field by field against the oldest prediction.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the engine backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import cpce_pkg::*;

  localparam int unsigned IdleLimit      = 2000;
  localparam int unsigned PressureCycles = 300;
  localparam int unsigned DrainCycles    = 4 * Capacity;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  circular_playlist_cursor_engine DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // playlist model and queue of predicted results
  class playlist_scoreboard;
    logic [SongW-1:0] songs [Capacity];
    int unsigned      count = 0;
    int unsigned      cursor = 0;
    out_t             expected_q [$];
    int unsigned      errors = 0;
    int unsigned      items_noted = 0;
    int unsigned      results_checked = 0;
    int unsigned      wrap_moves = 0;
    int unsigned      full_appends = 0;
    int unsigned      peak_len = 0;

    // single result describing the cursor after a command
    function out_t at_cursor(status_e st, logic wrap);
      out_t r;
      if (count == 0 || cursor >= count) begin
        r.current_song     = '0;
        r.current_position = '0;
      end else begin
        r.current_song     = songs[cursor];
        r.current_position = PosW'(cursor);
      end
      r.list_length = LenW'(count);
      r.status      = st;
      r.wrapped     = wrap;
      r.last_result = 1'b1;
      return r;
    endfunction

    // apply one accepted command and queue what it must produce
    function void note_input(in_t t);
      int unsigned slot;
      logic        wrap;
      out_t        r;
      items_noted++;
      case (t.operation)
        OP_APPEND: begin
          if (count >= Capacity) begin
            full_appends++;
            expected_q.push_back(at_cursor(ST_FULL, 1'b0));
          end else begin
            songs[count] = t.song_id;
            if (count == 0) cursor = 0;
            count++;
            expected_q.push_back(at_cursor(ST_OK, 1'b0));
          end
        end
        OP_DELETE: begin
          if (count == 0) begin
            expected_q.push_back(at_cursor(ST_EMPTY, 1'b0));
          end else if (t.delete_position < 1 || t.delete_position > count) begin
            expected_q.push_back(at_cursor(ST_INVALID, 1'b0));
          end else begin
            // close the gap, keep the cursor on its song or move it forward
            slot = t.delete_position - 1;
            for (int unsigned i = slot; i + 1 < count; i++) songs[i] = songs[i + 1];
            count--;
            if (slot < cursor) cursor--;
            if (cursor >= count) cursor = 0;
            expected_q.push_back(at_cursor(ST_OK, 1'b0));
          end
        end
        OP_NEXT, OP_PREV: begin
          if (count == 0) begin
            expected_q.push_back(at_cursor(ST_EMPTY, 1'b0));
          end else begin
            if (cursor >= count) cursor = 0;
            if (t.operation == OP_NEXT) begin
              wrap   = (cursor + 1 >= count);
              cursor = wrap ? 0 : cursor + 1;
            end else begin
              wrap   = (cursor == 0);
              cursor = wrap ? count - 1 : cursor - 1;
            end
            if (wrap) wrap_moves++;
            expected_q.push_back(at_cursor(ST_OK, wrap));
          end
        end
        OP_DUMP: begin
          if (count == 0) begin
            expected_q.push_back(at_cursor(ST_EMPTY, 1'b0));
          end else begin
            for (int unsigned i = 0; i < count; i++) begin
              r.current_song     = songs[i];
              r.current_position = PosW'(i);
              r.list_length      = LenW'(count);
              r.status           = ST_OK;
              r.wrapped          = 1'b0;
              r.last_result      = (i + 1 == count);
              expected_q.push_back(r);
            end
          end
        end
        default: begin
          expected_q.push_back(at_cursor(ST_INVALID, 1'b0));
        end
      endcase
      if (count > peak_len) peak_len = count;
    endfunction

    function void note_mismatch(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_t got);
      out_t want;
      results_checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.current_song !== want.current_song)
        note_mismatch("current_song", want.current_song, got.current_song);
      if (got.current_position !== want.current_position)
        note_mismatch("current_position", want.current_position, got.current_position);
      if (got.list_length !== want.list_length)
        note_mismatch("list_length", want.list_length, got.list_length);
      if (got.status !== want.status)
        note_mismatch("status", want.status, got.status);
      if (got.wrapped !== want.wrapped)
        note_mismatch("wrapped", want.wrapped, got.wrapped);
      if (got.last_result !== want.last_result)
        note_mismatch("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  playlist_scoreboard sb;
  int unsigned        send_quiet = 0;
  int unsigned        recv_quiet = 0;
  int unsigned        idle_cycles = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // per-transaction wait, with occasional runs of back-to-back traffic
  function automatic int unsigned draw_wait(inout int unsigned quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      quiet = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  // random command, mostly with a position that hits a live entry
  function automatic in_t random_item(int unsigned append_pct, int unsigned delete_pct);
    in_t         t;
    int unsigned pick;
    pick      = $urandom_range(0, 99);
    t.song_id = 16'($urandom);
    if (sb.count > 0 && $urandom_range(0, 4) != 0)
      t.delete_position = 7'($urandom_range(1, sb.count));
    else
      t.delete_position = 7'($urandom_range(0, 127));
    if (pick < append_pct) begin
      t.operation = OP_APPEND;
    end else if (pick < append_pct + delete_pct) begin
      t.operation = OP_DELETE;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick < 8)       t.operation = OP_NEXT;
      else if (pick < 16) t.operation = OP_PREV;
      else if (pick < 19) t.operation = OP_DUMP;
      else                t.operation = OP_DUMP + 3'($urandom_range(1, 3));
    end
    return t;
  endfunction

  function automatic in_t make_item(logic [OpW-1:0] op, logic [SongW-1:0] song,
                                    logic [DelW-1:0] del_pos);
    in_t t;
    t.operation       = op;
    t.song_id         = song;
    t.delete_position = del_pos;
    return t;
  endfunction

  // offer one transaction and hold it until the engine takes it
  task automatic send_item(input in_t t);
    int unsigned gap;
    gap = draw_wait(send_quiet);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_input(t);
  endtask

  // result side: random stalls, one long hold-off to back up the engine
  initial begin
    int unsigned w;
    bit          pressure_done;
    pressure_done = 1'b0;
    out_stall_i   = 1'b0;
    @(negedge clk_i);
    forever begin
      w = draw_wait(recv_quiet);
      if (!pressure_done && sb.results_checked >= 40) begin
        w             = PressureCycles;
        pressure_done = 1'b1;
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      sb.check_result(out_data_o);
      @(negedge clk_i);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_top: timeout after %0d idle cycles", idle_cycles);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    sb         = new;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list, unknown opcodes
    send_item(make_item(OP_NEXT, 16'h0000, 7'd0));
    send_item(make_item(OP_PREV, 16'hFFFF, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd1));
    send_item(make_item(OP_DUMP, 16'h0000, 7'd0));
    send_item(make_item(OP_DUMP + 3'd1, 16'hFFFF, 7'h7F));
    send_item(make_item(OP_DUMP + 3'd3, 16'h0000, 7'd0));
    // single entry: wrap both ways, then delete the only entry
    send_item(make_item(OP_APPEND, 16'h0000, 7'd0));
    send_item(make_item(OP_NEXT, 16'h0000, 7'd0));
    send_item(make_item(OP_PREV, 16'h0000, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd1));
    // short list, invalid positions, cursor adjustment on delete
    send_item(make_item(OP_APPEND, 16'hFFFF, 7'h7F));
    send_item(make_item(OP_APPEND, 16'h1234, 7'd0));
    send_item(make_item(OP_APPEND, 16'hA5A5, 7'd0));
    send_item(make_item(OP_APPEND, 16'h5A5A, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd64));
    send_item(make_item(OP_DELETE, 16'h0000, 7'h7F));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd5));
    send_item(make_item(OP_PREV, 16'h0000, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd4));
    send_item(make_item(OP_NEXT, 16'h0000, 7'd0));
    send_item(make_item(OP_NEXT, 16'h0000, 7'd0));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd1));
    send_item(make_item(OP_DELETE, 16'h0000, 7'd2));
    send_item(make_item(OP_DUMP, 16'h0000, 7'd0));

    // mixed traffic growing the list
    repeat (30) send_item(random_item(50, 15));
    // fill to capacity, then overfill
    while (sb.count < Capacity) send_item(random_item(100, 0));
    repeat (3) send_item(random_item(100, 0));
    send_item(make_item(OP_DUMP, 16'($urandom), 7'($urandom)));
    // shrinking traffic with frequent deletes
    repeat (25) send_item(random_item(15, 45));

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    end
    $display("tb_top: %0d commands, %0d results checked, peak length %0d",
             sb.items_noted, sb.results_checked, sb.peak_len);
    $display("tb_top: %0d cursor wraps, %0d appends refused as full, %0d errors",
             sb.wrap_moves, sb.full_appends, sb.errors);
    if (sb.errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
